FILE: hdl/pid_axis_step_macros.svh
// assertion macros for the checker module of the pid step block
// no dependencies; included by files that assert
`ifndef PID_AXIS_STEP_MACROS_SVH
`define PID_AXIS_STEP_MACROS_SVH

// same-cycle implication, disabled during reset
`define PAS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, disabled during reset
`define PAS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: hdl/pas_pkg.sv
// types, constants and helper functions for the pid step block
// no dependencies; used by every module of the block but the checker
`default_nettype none

package pas_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DT_FRAC       = 24;
  localparam logic [23:0] MIN_STEP = 24'd1678;

  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W = 57;
  localparam int DIV_D_W = 48;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_BAND   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILT_TAU   = 3'd6;

  typedef struct packed {
    logic signed [31:0] prop_gain;
    logic signed [31:0] integ_gain;
    logic signed [31:0] deriv_gain;
    logic [30:0]        integ_limit;
    logic [30:0]        drive_limit;
    logic [30:0]        separation_band;
    logic [30:0]        filter_tau;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic               neg;
    logic               frac_shift;  // 1: shift by fraction bits, 0: by dt fraction
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] value;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    abs32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [47:0] abs48(input logic signed [47:0] v);
    abs48 = v[47] ? 48'(-v) : 48'(v);
  endfunction

  function automatic logic [47:0] abs49(input logic signed [48:0] v);
    logic [48:0] t;
    t = v[48] ? 49'(-v) : 49'(v);
    abs49 = t[47:0];
  endfunction

  function automatic logic signed [63:0] clamp_sym(input logic signed [63:0] v,
                                                  input logic [30:0] lim);
    logic signed [63:0] hi;
    hi = $signed({33'd0, lim});
    if (v > hi) clamp_sym = hi;
    else if (v < -hi) clamp_sym = -hi;
    else clamp_sym = v;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/pas_cfg_regs.sv
// configuration register file of the pid step block
// depends on pas_pkg
`default_nettype none

module pas_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [pas_pkg::CFG_IDX_W-1:0]  index,
  input  wire logic [31:0]                    wr_data,
  output pas_pkg::cfg_t                       cfg
);
  import pas_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (index)
        REG_PROP_GAIN:  cfg_r.prop_gain       <= $signed(wr_data);
        REG_INTEG_GAIN: cfg_r.integ_gain      <= $signed(wr_data);
        REG_DERIV_GAIN: cfg_r.deriv_gain      <= $signed(wr_data);
        REG_INTEG_LIM:  cfg_r.integ_limit     <= wr_data[30:0];
        REG_DRIVE_LIM:  cfg_r.drive_limit     <= wr_data[30:0];
        REG_SEP_BAND:   cfg_r.separation_band <= wr_data[30:0];
        REG_FILT_TAU:   cfg_r.filter_tau      <= wr_data[30:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: hdl/pas_ser_mul.sv
// bit-serial shift-add multiplier: magnitude product, shift, saturate, sign
// depends on pas_pkg
`default_nettype none

module pas_ser_mul #(
  parameter int FRACTION_BITS = pas_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  pas_pkg::mul_req_t  req,
  output pas_pkg::mul_rsp_t  rsp
);
  import pas_pkg::*;

  localparam int CntW = $clog2(MUL_B_W);
  localparam logic [MUL_P_W-1:0] TermSat = MUL_P_W'(1) << 60;

  logic               busy_r, fin_r, neg_r, frac_r;
  logic [CntW-1:0]    cnt_r;
  logic [MUL_A_W-1:0] a_r;
  logic [MUL_B_W-1:0] b_r;
  logic [MUL_P_W-1:0] p_r, p_nxt;
  logic [MUL_A_W:0]   sum;
  logic [MUL_P_W-1:0] shifted;
  logic [60:0]        mag;
  mul_rsp_t           rsp_r;

  // one multiplier bit per cycle, lsb first
  always_comb begin
    sum   = {1'b0, p_r[MUL_P_W-1:MUL_B_W]} + (b_r[0] ? {1'b0, a_r} : '0);
    p_nxt = {sum, p_r[MUL_B_W-1:1]};
  end

  always_comb begin
    shifted = frac_r ? (p_r >> FRACTION_BITS) : (p_r >> DT_FRAC);
    mag     = (shifted > TermSat) ? TermSat[60:0] : shifted[60:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      fin_r      <= 1'b0;
      rsp_r.done <= 1'b0;
    end else begin
      rsp_r.done <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        a_r    <= req.a;
        b_r    <= req.b;
        neg_r  <= req.neg;
        frac_r <= req.frac_shift;
        p_r    <= '0;
      end else if (busy_r) begin
        p_r   <= p_nxt;
        b_r   <= b_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(MUL_B_W - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r       <= 1'b0;
        rsp_r.done  <= 1'b1;
        rsp_r.value <= neg_r ? -$signed({3'b000, mag}) : $signed({3'b000, mag});
      end
    end
  end

  assign rsp = rsp_r;

endmodule

`default_nettype wire

FILE: hdl/pas_ser_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on pas_pkg
`default_nettype none

module pas_ser_div (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  pas_pkg::div_req_t  req,
  output pas_pkg::div_rsp_t  rsp
);
  import pas_pkg::*;

  localparam int CntW = $clog2(DIV_N_W);

  logic               busy_r, done_r;
  logic [CntW-1:0]    cnt_r;
  logic [DIV_N_W-1:0] q_r;
  logic [DIV_D_W-1:0] rem_r, d_r;
  logic [DIV_D_W:0]   trial;
  logic               fits;

  always_comb begin
    trial = {rem_r, q_r[DIV_N_W-1]};
    fits  = trial >= {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= req.dividend;
        d_r    <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= fits ? DIV_D_W'(trial - {1'b0, d_r}) : trial[DIV_D_W-1:0];
        q_r   <= {q_r[DIV_N_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

`default_nettype wire

FILE: hdl/pid_axis_step.sv
// update with history and filter: five serial multiplies over a 32-bit
// multiplier operand and two serial divides of a 57-bit dividend;
// without history and with the filter off, both divides are skipped.
// small time step: straight to the output state, flagged; clear: no result.
// one item at a time; the next item may transfer while a result waits.
// rst_n synchronous active low: clears config, controller state and handshakes
`default_nettype none

module pid_axis_step #(
  parameter int FRACTION_BITS = pas_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output      logic                          in_tready,
  input  wire logic [55:0]                   in_tdata,   // error_sample, time_step
  input  wire logic [0:0]                    in_tuser,   // opcode
  output      logic                          out_tvalid,
  input  wire logic                          out_tready,
  output      logic [31:0]                   out_tdata,  // drive
  output      logic [0:0]                    out_tuser,  // step_too_small
  input  wire logic                          cfg_wr_en,
  input  wire logic [pas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_wr_data
);
  import pas_pkg::*;

  localparam int TauShift = DT_FRAC - FRACTION_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_IE    = 4'd1;
  localparam logic [3:0] S_RAW   = 4'd2;
  localparam logic [3:0] S_ALPHA = 4'd3;
  localparam logic [3:0] S_SLOPE = 4'd4;
  localparam logic [3:0] S_PTERM = 4'd5;
  localparam logic [3:0] S_ITERM = 4'd6;
  localparam logic [3:0] S_DTERM = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam logic signed [47:0] SlopeMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SlopeMin = 48'sh8000_0000_0000;

  cfg_t     cfg;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [3:0]         state_r;
  logic               go_r, flag_r;
  logic signed [31:0] e_r, integ_r, last_r;
  logic [23:0]        dt_r;
  logic signed [47:0] slope_r, raw_r;
  logic [24:0]        alpha_r;
  logic               hist_r;
  logic signed [63:0] acc_r;
  logic               out_valid_r, out_flag_r;
  logic [31:0]        out_drive_r;

  logic               accept;
  logic signed [32:0] diff_e;
  logic [47:0]        diff_e_abs;
  logic signed [48:0] diff_s;
  logic signed [63:0] integ_sum, integ_new, drive_cl;
  logic [47:0]        tau_den;
  logic signed [47:0] raw_q;
  logic               sep_out;

  pas_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_wr_en),
    .index   (cfg_index),
    .wr_data (cfg_wr_data),
    .cfg     (cfg)
  );

  pas_ser_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  pas_ser_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    diff_e     = 33'(e_r) - 33'(last_r);
    diff_e_abs = abs49(49'(diff_e));
    diff_s     = 49'(raw_r) - 49'(slope_r);
    integ_sum  = 64'(integ_r) + mul_rsp.value;
    integ_new  = clamp_sym(integ_sum, cfg.integ_limit);
    sep_out    = {1'b0, abs32(e_r)} > {2'b00, cfg.separation_band};
    tau_den    = (48'(cfg.filter_tau) << TauShift) + 48'(dt_r);
    drive_cl   = clamp_sym(acc_r, cfg.drive_limit);
    // quotient saturates to the 48-bit slope range
    if (diff_e[32]) begin
      raw_q = (div_rsp.quotient > 57'(48'h8000_0000_0000)) ? SlopeMin
            : -$signed(div_rsp.quotient[47:0]);
    end else begin
      raw_q = (div_rsp.quotient > 57'(SlopeMax)) ? SlopeMax
            : $signed(div_rsp.quotient[47:0]);
    end
  end

  // operand selection for the shared serial units
  always_comb begin
    mul_req = '0;
    div_req = '0;
    case (state_r)
      S_IE: begin
        mul_req.start = !go_r;
        mul_req.a     = 48'(abs32(e_r));
        mul_req.b     = 32'(dt_r);
        mul_req.neg   = e_r[31];
      end
      S_RAW: begin
        div_req.start    = !go_r && hist_r;
        div_req.dividend = {diff_e_abs[32:0], 24'd0};
        div_req.divisor  = 48'(dt_r);
      end
      S_ALPHA: begin
        div_req.start    = !go_r && (cfg.filter_tau != '0);
        div_req.dividend = {9'd0, dt_r, 24'd0};
        div_req.divisor  = tau_den;
      end
      S_SLOPE: begin
        mul_req.start = !go_r;
        mul_req.a     = abs49(diff_s);
        mul_req.b     = 32'(alpha_r);
        mul_req.neg   = diff_s[48];
      end
      S_PTERM: begin
        mul_req.start      = !go_r;
        mul_req.frac_shift = 1'b1;
        mul_req.a          = 48'(abs32(e_r));
        mul_req.b          = abs32(cfg.prop_gain);
        mul_req.neg        = e_r[31] ^ cfg.prop_gain[31];
      end
      S_ITERM: begin
        mul_req.start      = !go_r;
        mul_req.frac_shift = 1'b1;
        mul_req.a          = 48'(abs32(integ_r));
        mul_req.b          = abs32(cfg.integ_gain);
        mul_req.neg        = integ_r[31] ^ cfg.integ_gain[31];
      end
      S_DTERM: begin
        mul_req.start      = !go_r;
        mul_req.frac_shift = 1'b1;
        mul_req.a          = abs48(slope_r);
        mul_req.b          = abs32(cfg.deriv_gain);
        mul_req.neg        = slope_r[47] ^ cfg.deriv_gain[31];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      last_r      <= '0;
      slope_r     <= '0;
      hist_r      <= 1'b0;
    end else begin
      if (out_tready && (state_r != S_OUT)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            e_r   <= $signed(in_tdata[31:0]);
            dt_r  <= in_tdata[55:32];
            acc_r <= '0;
            if (in_tuser[0]) begin
              integ_r <= '0;
              last_r  <= '0;
              slope_r <= '0;
              hist_r  <= 1'b0;
            end else if (in_tdata[55:32] < MIN_STEP) begin
              flag_r  <= 1'b1;
              state_r <= S_OUT;
            end else begin
              flag_r  <= 1'b0;
              state_r <= S_IE;
            end
          end
        end
        S_IE: begin
          if (!go_r) go_r <= 1'b1;
          else if (mul_rsp.done) begin
            go_r    <= 1'b0;
            integ_r <= sep_out ? '0 : integ_new[31:0];
            state_r <= S_RAW;
          end
        end
        S_RAW: begin
          if (!hist_r) begin
            raw_r   <= '0;
            state_r <= S_ALPHA;
          end else if (!go_r) go_r <= 1'b1;
          else if (div_rsp.done) begin
            go_r    <= 1'b0;
            raw_r   <= raw_q;
            state_r <= S_ALPHA;
          end
        end
        S_ALPHA: begin
          if (cfg.filter_tau == '0) begin
            alpha_r <= 25'd1 << DT_FRAC;
            state_r <= S_SLOPE;
          end else if (!go_r) go_r <= 1'b1;
          else if (div_rsp.done) begin
            go_r    <= 1'b0;
            alpha_r <= div_rsp.quotient[24:0];
            state_r <= S_SLOPE;
          end
        end
        S_SLOPE: begin
          if (!go_r) go_r <= 1'b1;
          else if (mul_rsp.done) begin
            go_r    <= 1'b0;
            slope_r <= slope_r + mul_rsp.value[47:0];
            last_r  <= e_r;
            hist_r  <= 1'b1;
            state_r <= S_PTERM;
          end
        end
        S_PTERM, S_ITERM, S_DTERM: begin
          if (!go_r) go_r <= 1'b1;
          else if (mul_rsp.done) begin
            go_r    <= 1'b0;
            acc_r   <= acc_r + mul_rsp.value;
            state_r <= (state_r == S_PTERM) ? S_ITERM
                     : (state_r == S_ITERM) ? S_DTERM : S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_flag_r  <= flag_r;
            out_drive_r <= flag_r ? '0 : drive_cl[31:0];
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_drive_r;
  assign out_tuser  = out_flag_r;

endmodule

`default_nettype wire

FILE: hdl/pas_checker.sv
// port-level checks for pid_axis_step, bound to the top level
// depends on pid_axis_step_macros.svh
`default_nettype none
`include "pid_axis_step_macros.svh"

module pas_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [0:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [0:0]  out_tuser
);

  // result held while the sink stalls
  `PAS_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // a flagged result carries zero drive
  `PAS_ASSERT_IMP(a_flag_zero, clk, rst_n, out_tvalid && out_tuser[0], out_tdata == 32'd0)

  // an update transfer makes the block busy
  `PAS_ASSERT_NXT(a_busy_after_update, clk, rst_n, in_tvalid && in_tready && !in_tuser[0], !in_tready)

  // a clear gives no result
  `PAS_ASSERT_NXT(a_clear_silent, clk, rst_n, in_tvalid && in_tready && in_tuser[0] && !out_tvalid, !out_tvalid)

endmodule

bind pid_axis_step pas_checker u_pas_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

FILE: verif/tb_pid_axis_step.sv
// self-checking testbench for the pid_axis_step stream block
// depends on pas_pkg and the pid_axis_step rtl; predicts each drive and flag in its own model
`default_nettype none

module tb_pid_axis_step;
  timeunit 1ns;
  timeprecision 1ps;

  import pas_pkg::*;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int   FRAC = FRAC_BITS_DEF;
  localparam longint unsigned TERM_SAT = 64'd1 << 60;
  localparam longint SLOPE_MAX = (64'sd1 <<< 47) - 1;
  localparam longint SLOPE_MIN = -(64'sd1 <<< 47);
  localparam int SETTLE_CYCLES = 400;
  localparam int STALL_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 3000;

  typedef struct {
    logic signed [31:0] drive;
    logic               too_small;
  } pid_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] in_tdata = '0;   // error_sample[31:0], time_step[55:32]
  logic [0:0]  in_tuser = '0;   // opcode
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;       // drive
  logic [0:0]  out_tuser;       // step_too_small
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_wr_data = '0;

  pid_axis_step dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  // predictor copy of configuration and controller state
  longint kp, ki, kd, integ_lim, drive_lim, sep_band, tau;
  longint integ_acc, prev_err, slope_filt;
  bit     primed;

  pid_result_t expected_drive_q[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  // product shifted right, truncated toward zero, saturated at 2^60
  function automatic longint scaled_product(longint a, longint b, int sh);
    bit neg;
    longint unsigned ma, mb, hi, lo, m;
    neg = (a < 0) != (b < 0);
    ma = magnitude(a);
    mb = magnitude(b);
    hi = mb >> sh;
    lo = mb & ((64'd1 << sh) - 64'd1);
    if (hi != 0 && ma > TERM_SAT / hi) begin
      m = TERM_SAT;
    end else begin
      m = ma * hi + ((ma * lo) >> sh);
      if (m > TERM_SAT) m = TERM_SAT;
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic bit pid_predict(logic op, logic signed [31:0] err_in, logic [23:0] dt_in,
                                     output pid_result_t res);
    longint e, dt, raw, alpha, drv;
    longint unsigned den;
    e = err_in;
    dt = dt_in;
    res.drive = '0;
    res.too_small = 1'b0;
    if (op == OP_CLEAR) begin
      integ_acc = 0; prev_err = 0; slope_filt = 0; primed = 0;
      return 0;
    end
    if (dt_in < MIN_STEP) begin
      res.too_small = 1'b1;
      return 1;
    end
    if (longint'(magnitude(e)) <= sep_band)
      integ_acc = clamp_mag(integ_acc + scaled_product(dt, e, DT_FRAC), integ_lim);
    else
      integ_acc = 0;
    if (primed) begin
      raw = ((e - prev_err) * 64'sd16777216) / dt;
      if (raw > SLOPE_MAX) raw = SLOPE_MAX;
      if (raw < SLOPE_MIN) raw = SLOPE_MIN;
    end else begin
      raw = 0;
    end
    if (tau == 0) begin
      alpha = 64'sd1 <<< DT_FRAC;
    end else begin
      den = (longint'(tau) << (DT_FRAC - FRAC)) + dt;
      alpha = longint'((longint'(dt) << DT_FRAC) / den);
    end
    slope_filt += scaled_product(alpha, raw - slope_filt, DT_FRAC);
    prev_err = e;
    primed = 1;
    drv = scaled_product(kp, e, FRAC) + scaled_product(ki, integ_acc, FRAC)
        + scaled_product(kd, slope_filt, FRAC);
    res.drive = 32'(clamp_mag(drv, drive_lim));
    return 1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    pid_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_drive_q.size() == 0) begin
        report_mismatch("unexpected result drive", $signed(out_tdata), 0);
      end else begin
        want = expected_drive_q.pop_front();
        if (out_tdata !== want.drive)
          report_mismatch("drive", $signed(out_tdata), want.drive);
        if (out_tuser[0] !== want.too_small)
          report_mismatch("step_too_small", out_tuser[0], want.too_small);
      end
    end
  end

  // receiver readiness, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(logic op, logic signed [31:0] e, logic [23:0] dt);
    pid_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {dt, e};
    do @(posedge clk); while (!in_tready);
    if (pid_predict(op, e, dt, res)) expected_drive_q = {expected_drive_q, res};
    @(negedge clk);
  endtask

  // wait for all results, then let any clear still in flight finish
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_drive_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_PROP_GAIN:  kp = $signed(val);
      REG_INTEG_GAIN: ki = $signed(val);
      REG_DERIV_GAIN: kd = $signed(val);
      REG_INTEG_LIM:  integ_lim = val[30:0];
      REG_DRIVE_LIM:  drive_lim = val[30:0];
      REG_SEP_BAND:   sep_band = val[30:0];
      REG_FILT_TAU:   tau = val[30:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic [31:0] p, logic [31:0] i, logic [31:0] d, logic [31:0] il,
                             logic [31:0] dl, logic [31:0] sb, logic [31:0] ft);
    settle();
    write_reg(REG_PROP_GAIN, p);
    write_reg(REG_INTEG_GAIN, i);
    write_reg(REG_DERIV_GAIN, d);
    write_reg(REG_INTEG_LIM, il);
    write_reg(REG_DRIVE_LIM, dl);
    write_reg(REG_SEP_BAND, sb);
    write_reg(REG_FILT_TAU, ft);
  endtask

  function automatic logic [31:0] rand_gain();
    int r;
    r = $urandom_range(9);
    if (r == 0) return $urandom;
    return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
  endfunction

  task automatic random_config();
    load_config(rand_gain(), rand_gain(), rand_gain(), $urandom, $urandom,
                ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h000F_FFFF),
                ($urandom_range(2) == 0) ? 32'd0 :
                ($urandom_range(1) ? $urandom : $urandom_range(32'h0004_0000)));
  endtask

  task automatic random_item();
    int r;
    logic signed [31:0] e;
    logic [23:0] dt;
    r = $urandom_range(99);
    case ($urandom_range(3))
      0: e = $urandom;
      1: e = 32'(sep_band + $signed($urandom_range(4)) - 2) * ($urandom_range(1) ? 1 : -1);
      default: e = 32'($signed($urandom_range(1 << 21)) - (1 << 20));
    endcase
    if (r < 3) begin
      send_item(OP_CLEAR, $urandom, $urandom);
    end else if (r < 8) begin
      send_item(OP_UPDATE, e, 24'($urandom_range(MIN_STEP - 1)));
    end else begin
      dt = ($urandom_range(3) == 0) ? 24'($urandom_range(24'hFF_FFFF, MIN_STEP))
                                    : 24'($urandom_range(200000, MIN_STEP));
      send_item(OP_UPDATE, e, dt);
    end
  endtask

  task automatic test_directed();
    load_config(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h000A_0000,
                32'h0064_0000, 32'h0005_0000, 32'd0);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_item(OP_UPDATE, 32'h0001_0000, 24'd167772);  // first sample, no slope
    send_item(OP_UPDATE, 32'h0002_0000, 24'd167772);
    send_item(OP_UPDATE, 32'h0002_0000, 24'd0);       // step below minimum
    send_item(OP_UPDATE, 32'h0002_0000, MIN_STEP - 24'd1);
    send_item(OP_UPDATE, -32'sh0003_0000, MIN_STEP);
    send_item(OP_UPDATE, 32'h0005_0000, 24'hFF_FFFF); // error right at the band
    send_item(OP_UPDATE, -32'sh0005_0000, MIN_STEP);
    send_item(OP_UPDATE, 32'h0005_0001, 24'd1000000); // just outside, integral zeroed
    send_item(OP_UPDATE, 32'h7FFF_FFFF, MIN_STEP);    // large slope, still inside the slope range
    send_item(OP_UPDATE, 32'h8000_0000, MIN_STEP);
    send_item(OP_CLEAR, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send_item(OP_UPDATE, 32'h0000_1000, 24'd50000);   // slope zero again after clear
    load_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(OP_UPDATE, 32'h8000_0000, 24'hFF_FFFF); // magnitude above every band
    send_item(OP_UPDATE, 32'h7FFF_FFFF, 24'hFF_FFFF);
    send_item(OP_UPDATE, 32'h8000_0000, MIN_STEP);
    load_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'd1);
    send_item(OP_UPDATE, 32'd0, MIN_STEP);
    send_item(OP_UPDATE, 32'h0000_0001, 24'hFF_FFFF);
    load_config(32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0010_0000,
                32'hFFFF_FFFF, 32'h8000_0000, 32'd0);
    send_item(OP_UPDATE, 32'h7FFF_FFFF, 24'd3000);
    send_item(OP_UPDATE, 32'h8000_0000, 24'd3000);
    send_item(OP_UPDATE, 32'h1234_5678, 24'd3000);
  endtask

  task automatic test_random(int sidle, int ridle, int count);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int n = 0; n < count; n++) begin
      if (n % 45 == 0) random_config();
      random_item();
    end
  endtask

  task automatic test_backpressure();
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = HOLD_CYCLES;
    for (int n = 0; n < 20; n++) random_item();
  endtask

  initial begin
    kp = 0; ki = 0; kd = 0; integ_lim = 0; drive_lim = 0; sep_band = 0; tau = 0;
    integ_acc = 0; prev_err = 0; slope_filt = 0; primed = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(6, 61, 270);
    test_random(61, 6, 270);
    test_random(0, 0, 260);
    test_backpressure();
    settle();
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+hdl
hdl/pas_pkg.sv
hdl/pas_cfg_regs.sv
hdl/pas_ser_mul.sv
hdl/pas_ser_div.sv
hdl/pid_axis_step.sv
hdl/pas_checker.sv
verif/tb_pid_axis_step.sv
